FILE: design/srf_pkg.sv
// shared types and constants for the slip/udp receive filter
// no dependencies; used by front, back and top level
package srf_pkg;

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [3:0] IP_VERSION   = 4'd4;
  localparam logic [3:0] IHL_MASK     = 4'h0F;

  localparam int HDR_BYTES  = 28;
  localparam int CMD_ADDR_W = 14;
  localparam int CMD_DEPTH  = 4;
  localparam int RES_DEPTH  = 4;
  localparam int RES_CNT_W  = 3;

  localparam logic REG_LOCAL_IP   = 1'b0;
  localparam logic REG_LOCAL_PORT = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_DELIVER = 2'd2
  } cmd_code_t;

  typedef enum logic {
    KIND_DELIVER = 1'b0,
    KIND_READ    = 1'b1
  } kind_t;

  typedef struct packed {
    cmd_code_t             code;
    logic                  ok;
    logic [CMD_ADDR_W-1:0] addr;
    logic [7:0]            data;
    logic [31:0]           ip;
    logic [15:0]           port;
    logic [10:0]           len;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] ip;
    logic [15:0] port;
    logic [10:0] len;
    logic [7:0]  data;
  } result_t;

endpackage

FILE: design/slip_udp_ipv4_receive_filter_unit.sv
// slip deframer with ipv4/udp destination filter, top level
// a result passes the command queue, the back stage register and the result queue
// one item per cycle unless full; the front decodes, the back owns the frame memory port
// a 4-entry command queue and a 4-entry result queue decouple the two halves
// reset clears control and filter regs, not data regs or frame memory (no clearing pass)
module slip_udp_ipv4_receive_filter_unit #(
  parameter int MAX_MESSAGE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [7:0]  rx_byte,
  input  logic [9:0]  read_index,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [31:0] sender_ip,
  output logic [15:0] sender_port,
  output logic [10:0] payload_length,
  output logic [7:0]  read_data
);

  localparam int CMD_W = $bits(srf_pkg::cmd_t);
  localparam int RES_W = $bits(srf_pkg::result_t);

  logic [31:0] filter_ip;
  logic [15:0] filter_port;
  logic        accept;
  logic        cmd_push;
  srf_pkg::cmd_t    cmd_in;
  srf_pkg::cmd_t    cmd_out;
  logic [CMD_W-1:0] cmd_bits;
  logic        cmd_empty;
  logic        cmd_pop;
  logic [$clog2(srf_pkg::CMD_DEPTH+1)-1:0] cmd_count;
  logic        res_push;
  srf_pkg::result_t res_in;
  srf_pkg::result_t res_out;
  logic [RES_W-1:0] res_bits;
  logic        res_full;
  logic [srf_pkg::RES_CNT_W-1:0] res_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_ip   <= '0;
      filter_port <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        srf_pkg::REG_LOCAL_IP:   filter_ip   <= pwdata;
        srf_pkg::REG_LOCAL_PORT: filter_port <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      srf_pkg::REG_LOCAL_IP:   prdata = filter_ip;
      srf_pkg::REG_LOCAL_PORT: prdata = {16'd0, filter_port};
      default:                 prdata = '0;
    endcase
  end

  assign accept = push && !full;

  srf_front #(.MAX_MESSAGE(MAX_MESSAGE)) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .op          (op),
    .rx_byte     (rx_byte),
    .read_index  (read_index),
    .filter_ip   (filter_ip),
    .filter_port (filter_port),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  srf_fifo #(.WIDTH(CMD_W), .DEPTH(srf_pkg::CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_bits),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  assign cmd_out = srf_pkg::cmd_t'(cmd_bits);

  srf_back #(.MAX_MESSAGE(MAX_MESSAGE)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res       (res_in)
  );

  srf_fifo #(.WIDTH(RES_W), .DEPTH(srf_pkg::RES_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_bits),
    .empty (empty),
    .count (res_count)
  );

  assign res_out        = srf_pkg::result_t'(res_bits);
  assign kind           = res_out.kind;
  assign sender_ip      = res_out.ip;
  assign sender_port    = res_out.port;
  assign payload_length = res_out.len;
  assign read_data      = res_out.data;

`ifndef SYNTHESIS
  a_cmd_bound: assert property (@(posedge clk) disable iff (rst)
    cmd_count <= ($clog2(srf_pkg::CMD_DEPTH+1))'(srf_pkg::CMD_DEPTH))
    else $error("command queue count out of range");
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_full |-> !res_push)
    else $error("result queue overflow");
  a_cfg_idle_ok: assert property (@(posedge clk) disable iff (rst)
    (cmd_push && !full) |=> !cmd_empty)
    else $error("queued command vanished");
`endif

endmodule

FILE: design/srf_fifo.sv
// small register queue used between front and back and on the result side
// no package dependencies
module srf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/srf_front.sv
// front end: slip decoding, header capture as bytes arrive, frame check
// emits write, read and deliver commands; uses srf_pkg
module srf_front #(
  parameter int MAX_MESSAGE = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          op,
  input  logic [7:0]    rx_byte,
  input  logic [9:0]    read_index,
  input  logic [31:0]   filter_ip,
  input  logic [15:0]   filter_port,
  output logic          cmd_push,
  output srf_pkg::cmd_t cmd
);

  localparam int FRAME_CAP = srf_pkg::HDR_BYTES + MAX_MESSAGE;
  localparam int LW        = $clog2(FRAME_CAP + 1);

  logic          escape_pending, escape_pending_next;
  logic          frame_open, frame_open_next;
  logic          overflowed, overflowed_next;
  logic [LW-1:0] frame_length, frame_length_next;
  logic [6:0]    payload_start, payload_start_next;
  logic          readable, readable_next;
  logic [LW-1:0] delivered_len, delivered_len_next;

  logic [7:0]  hdr0;
  logic [7:0]  proto;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] src_port;
  logic [15:0] dest_port;
  logic [15:0] udp_len;

  logic        put_req;
  logic [7:0]  put_val;
  logic        store_en;
  logic [5:0]  ihl;
  logic [16:0] n_w;
  logic [16:0] ihl_w;
  logic [16:0] pos_w;
  logic [15:0] body;
  logic        pass;
  logic [15:0] rd_addr;

  assign ihl   = {hdr0[3:0] & srf_pkg::IHL_MASK, 2'b00};
  assign n_w   = 17'(frame_length);
  assign ihl_w = 17'(ihl);
  assign pos_w = 17'(frame_length);
  assign body  = udp_len - 16'd8;

  // all header fields are captured while the frame streams in
  assign pass = (n_w >= 17'(srf_pkg::HDR_BYTES)) && (hdr0[7:4] == srf_pkg::IP_VERSION)
             && (ihl >= 6'd20) && (n_w >= ihl_w + 17'd8)
             && (proto == srf_pkg::PROTO_UDP) && (dst_ip == filter_ip)
             && (dest_port == filter_port) && (udp_len >= 16'd8)
             && (ihl_w + 17'(udp_len) <= n_w);

  assign rd_addr = 16'(payload_start) + 16'(read_index);

  always_comb begin
    escape_pending_next = escape_pending;
    frame_open_next     = frame_open;
    overflowed_next     = overflowed;
    frame_length_next   = frame_length;
    payload_start_next  = payload_start;
    readable_next       = readable;
    delivered_len_next  = delivered_len;
    put_req             = 1'b0;
    put_val             = rx_byte;
    store_en            = 1'b0;
    cmd_push            = 1'b0;
    cmd                 = '0;
    if (accept) begin
      if (op) begin
        cmd_push  = 1'b1;
        cmd.code  = srf_pkg::CMD_READ;
        cmd.ok    = readable && (16'(read_index) < 16'(delivered_len));
        cmd.addr  = rd_addr[srf_pkg::CMD_ADDR_W-1:0];
      end else begin
        readable_next = 1'b0;
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          if (rx_byte == srf_pkg::SLIP_ESC_END) begin
            put_req = 1'b1;
            put_val = srf_pkg::SLIP_END;
          end else if (rx_byte == srf_pkg::SLIP_ESC_ESC) begin
            put_req = 1'b1;
            put_val = srf_pkg::SLIP_ESC;
          end else begin
            // bad escape drops the frame and leaves frame mode
            frame_length_next = '0;
            frame_open_next   = 1'b0;
            overflowed_next   = 1'b0;
          end
        end else if (rx_byte == srf_pkg::SLIP_END) begin
          if (frame_open && (frame_length != '0) && !overflowed && pass) begin
            cmd_push           = 1'b1;
            cmd.code           = srf_pkg::CMD_DELIVER;
            cmd.ip             = src_ip;
            cmd.port           = src_port;
            cmd.len            = body[10:0];
            payload_start_next = 7'(ihl) + 7'd8;
            delivered_len_next = LW'(body);
            readable_next      = 1'b1;
          end
          frame_length_next = '0;
          frame_open_next   = 1'b1;
          overflowed_next   = 1'b0;
        end else if (rx_byte == srf_pkg::SLIP_ESC) begin
          escape_pending_next = 1'b1;
        end else begin
          put_req = 1'b1;
        end
        if (put_req && frame_open) begin
          if (frame_length < LW'(FRAME_CAP)) begin
            store_en                  = 1'b1;
            cmd_push                  = 1'b1;
            cmd.code                  = srf_pkg::CMD_WRITE;
            cmd.addr[LW-1:0]          = frame_length;
            cmd.data                  = put_val;
            frame_length_next         = frame_length + 1'b1;
          end else begin
            overflowed_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      frame_open     <= 1'b0;
      overflowed     <= 1'b0;
      frame_length   <= '0;
      payload_start  <= '0;
      readable       <= 1'b0;
      delivered_len  <= '0;
    end else begin
      escape_pending <= escape_pending_next;
      frame_open     <= frame_open_next;
      overflowed     <= overflowed_next;
      frame_length   <= frame_length_next;
      payload_start  <= payload_start_next;
      readable       <= readable_next;
      delivered_len  <= delivered_len_next;
    end
  end

  // bytes are stored in order, so multi-byte fields shift in
  always_ff @(posedge clk) begin
    if (store_en) begin
      if (pos_w == 17'd0) hdr0 <= put_val;
      if (pos_w == 17'd9) proto <= put_val;
      if (pos_w >= 17'd12 && pos_w <= 17'd15) src_ip <= {src_ip[23:0], put_val};
      if (pos_w >= 17'd16 && pos_w <= 17'd19) dst_ip <= {dst_ip[23:0], put_val};
      if (pos_w == ihl_w || pos_w == ihl_w + 17'd1) begin
        src_port <= {src_port[7:0], put_val};
      end
      if (pos_w == ihl_w + 17'd2 || pos_w == ihl_w + 17'd3) begin
        dest_port <= {dest_port[7:0], put_val};
      end
      if (pos_w == ihl_w + 17'd4 || pos_w == ihl_w + 17'd5) begin
        udp_len <= {udp_len[7:0], put_val};
      end
    end
  end

endmodule

FILE: design/srf_back.sv
// back end: frame memory, executes queued commands in order, forms results
// uses srf_pkg; feeds the result queue in the top level
module srf_back #(
  parameter int MAX_MESSAGE = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_empty,
  input  srf_pkg::cmd_t                    cmd,
  output logic                             cmd_pop,
  input  logic [srf_pkg::RES_CNT_W-1:0]    res_count,
  output logic                             res_push,
  output srf_pkg::result_t                 res
);

  localparam int FRAME_CAP = srf_pkg::HDR_BYTES + MAX_MESSAGE;
  localparam int AW        = $clog2(FRAME_CAP);

  logic [7:0]     frame_mem [FRAME_CAP];
  logic [7:0]     mem_q;
  logic           room;
  logic           s1_valid;
  srf_pkg::kind_t s1_kind;
  logic           s1_ok;
  logic [31:0]    s1_ip;
  logic [15:0]    s1_port;
  logic [10:0]    s1_len;

  // count the item in the stage so the result queue never overfills
  assign room    = ((srf_pkg::RES_CNT_W + 1)'(res_count) + (srf_pkg::RES_CNT_W + 1)'(s1_valid))
                   < (srf_pkg::RES_CNT_W + 1)'(srf_pkg::RES_DEPTH);
  assign cmd_pop = !cmd_empty && room;

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      if (cmd.code == srf_pkg::CMD_WRITE) begin
        frame_mem[cmd.addr[AW-1:0]] <= cmd.data;
      end
      mem_q <= frame_mem[cmd.addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_pop && (cmd.code == srf_pkg::CMD_READ || cmd.code == srf_pkg::CMD_DELIVER);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_ok <= cmd.ok;
      unique case (cmd.code)
        srf_pkg::CMD_DELIVER: begin
          s1_kind <= srf_pkg::KIND_DELIVER;
          s1_ip   <= cmd.ip;
          s1_port <= cmd.port;
          s1_len  <= cmd.len;
        end
        default: begin
          s1_kind <= srf_pkg::KIND_READ;
          s1_ip   <= '0;
          s1_port <= '0;
          s1_len  <= '0;
        end
      endcase
    end
  end

  assign res_push  = s1_valid;
  assign res.kind  = s1_kind;
  assign res.ip    = s1_ip;
  assign res.port  = s1_port;
  assign res.len   = s1_len;
  assign res.data  = (s1_kind == srf_pkg::KIND_READ && s1_ok) ? mem_q : 8'd0;

`ifndef SYNTHESIS
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd.code == srf_pkg::CMD_WRITE) |=> !s1_valid)
    else $error("write command produced a result");
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && cmd.code == srf_pkg::CMD_READ) |=>
      (s1_valid && s1_kind == srf_pkg::KIND_READ))
    else $error("read command lost");
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res_count != srf_pkg::RES_CNT_W'(srf_pkg::RES_DEPTH)))
    else $error("result pushed into full queue");
`endif

endmodule
